FILE: hdl/vseb_pkg.sv
// Package for the variation-set error band block.
// Holds widths, mode and register codes, and the control struct of the shared
// divide/square-root unit. No dependencies.
package vseb_pkg;

  localparam int MaxSetsDef   = 1024;
  localparam int ValueBitsDef = 32;
  localparam int FieldW       = 32;  // width of a value field on the stream
  localparam int SumW         = 48;  // signed sum of values
  localparam int AccW         = 64;  // Q16.48 square sums
  localparam int ErrRawW      = 32;  // root or magnitude before clipping
  localparam int ErrW         = 31;  // clipped error, unsigned Q7.24
  localparam int CfgIdxW      = 1;
  localparam int CfgDataW     = 2;

  typedef enum logic [1:0] {
    MODE_REPLICA   = 2'd0,
    MODE_PAIRED    = 2'd1,
    MODE_DEVIATION = 2'd2,
    MODE_ENVELOPE  = 2'd3
  } mode_e;

  localparam logic [CfgIdxW-1:0] CFG_ERROR_MODE = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_SYMMETRIC  = 1'b1;

  typedef enum logic {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } iter_op_e;

  typedef struct packed {
    logic     start;
    iter_op_e op;
  } iter_ctrl_t;

  // which square sums take the current product, and whether it is quartered
  typedef struct packed {
    logic to_minus;
    logic to_plus;
    logic quarter;
  } acc_sel_t;

  function automatic logic [ErrW-1:0] clip_err(logic [ErrRawW-1:0] v);
    logic [ErrW-1:0] r;
    r = v[ErrRawW-1] ? {ErrW{1'b1}} : v[ErrW-1:0];
    return r;
  endfunction

endpackage

FILE: hdl/vseb_mul.sv
// Registered squaring unit shared by accumulation and the final mean square.
// Depends on nothing but its parameter.
module vseb_mul #(
  parameter int OpW = 32
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [OpW-1:0]   a_i,
  output logic [2*OpW-1:0] prod_o
);

  logic [2*OpW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * a_i;
    end
  end

  assign prod_o = prod_q;

endmodule

FILE: hdl/vseb_iter.sv
// Shared iterative unit: restoring divide (one bit a cycle) and integer
// square root (two radicand bits a cycle) over one compare-subtract.
// Depends on vseb_pkg.
module vseb_iter
  import vseb_pkg::*;
#(
  parameter int DivisorW = 11
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  iter_ctrl_t          ctrl_i,
  input  logic [AccW-1:0]     opnd_i,
  input  logic [DivisorW-1:0] divisor_i,
  output logic                busy_o,
  output logic                done_o,
  output logic [AccW-1:0]     result_o
);

  localparam int RemW      = (DivisorW + 1 > 36) ? DivisorW + 1 : 36;
  localparam int DivSteps  = AccW;
  localparam int SqrtSteps = AccW / 2;
  localparam int StepW     = $clog2(DivSteps);

  logic             busy_q, done_q;
  iter_op_e         op_q;
  logic [StepW-1:0] step_q;
  logic [RemW-1:0]  rem_q;
  logic [AccW-1:0]  src_q, res_q;

  logic [RemW-1:0]  cand, trial;
  logic [RemW:0]    diff;
  logic             ge, last_step;

  always_comb begin
    if (op_q == OP_DIV) begin
      cand  = {rem_q[RemW-2:0], src_q[AccW-1]};
      trial = RemW'(divisor_i);
    end else begin
      cand  = {rem_q[RemW-3:0], src_q[AccW-1:AccW-2]};
      trial = {res_q[RemW-3:0], 2'b01};
    end
    diff      = {1'b0, cand} - {1'b0, trial};
    ge        = ~diff[RemW];
    last_step = (op_q == OP_DIV) ? (step_q == StepW'(DivSteps - 1))
                                 : (step_q == StepW'(SqrtSteps - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_DIV;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        op_q   <= ctrl_i.op;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (last_step) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      rem_q <= '0;
      src_q <= opnd_i;
      res_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[RemW-1:0] : cand;
      src_q <= (op_q == OP_DIV) ? {src_q[AccW-2:0], 1'b0} : {src_q[AccW-3:0], 2'b00};
      res_q <= {res_q[AccW-2:0], ge};
    end
  end

  assign busy_o   = busy_q;
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

FILE: hdl/variation_set_error_band.sv
// Variation-set error band: accumulates a run of variation values per point.
// A non-last item holds ready low while it is registered, checked, and put through a
// square plus saturating add (twice for an asymmetric pair). A last item adds the
// final pass: two 32-step roots for the root modes, two 64-step divides and one root
// for replica std dev, and no divide or root for the envelope.
// One item at a time. Reset (async, low) clears all sums, error_mode 1, symmetric 0.
module variation_set_error_band
  import vseb_pkg::*;
#(
  parameter int MAX_SETS   = MaxSetsDef,
  parameter int VALUE_BITS = ValueBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [CfgDataW-1:0]   cfg_data_i,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [2*FieldW-1:0]   s_axis_tdata,   // central_value, variation_value
  input  logic                  s_axis_tlast,   // last
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [2*FieldW-1:0]   m_axis_tdata,   // error_minus, error_plus, zero pad
  output logic                  m_axis_tuser    // saturated
);

  localparam int CntW = $clog2(MAX_SETS + 1);
  localparam int SW   = VALUE_BITS + 1;
  localparam int MagW = VALUE_BITS;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_ITEM = 11'b00000000010,
    S_MUL  = 11'b00000000100,
    S_ADD  = 11'b00000001000,
    S_CHK  = 11'b00000010000,
    S_DIV1 = 11'b00000100000,
    S_MSQ  = 11'b00001000000,
    S_DIV2 = 11'b00010000000,
    S_SQ1  = 11'b00100000000,
    S_SQ2  = 11'b01000000000,
    S_OUT  = 11'b10000000000
  } state_e;

  state_e                  state_q;
  mode_e                   mode_q;
  logic                    sym_q;
  logic signed [SW-1:0]    cent_q, var_q, held_q;
  logic                    last_q, phase_q, second_q, acc_sat_q;
  logic signed [SumW-1:0]  vsum_q;
  logic [AccW-1:0]         msum_q, psum_q;
  logic [CntW-1:0]         cnt_q;
  logic [MagW-1:0]         max_up_q, max_dn_q, mul_a_q, pend_q;
  acc_sel_t                sel_q;
  logic [ErrRawW-1:0]      em_q, ep_q;
  logic                    m_valid_q, out_sat_q;
  logic [ErrW-1:0]         out_em_q, out_ep_q;

  logic signed [VALUE_BITS-1:0] cent_raw, var_raw;
  logic [2*MagW-1:0]       prod;
  logic [AccW-1:0]         prod64, addend, vsum_abs, iter_res, iter_opnd;
  logic [AccW:0]           msum_add, psum_add;
  logic signed [SW-1:0]    dev, d1, d2, pdiff, ed, ep_neg;
  logic [SW-1:0]           dev_abs, var_abs, pdiff_abs, ued, uep;
  logic                    iter_busy, iter_done, out_free;
  iter_ctrl_t              iter_ctrl;

  assign cent_raw = s_axis_tdata[VALUE_BITS-1:0];
  assign var_raw  = s_axis_tdata[FieldW+VALUE_BITS-1:FieldW];
  assign out_free = ~m_valid_q | m_axis_tready;

  always_comb begin
    dev       = var_q - cent_q;
    dev_abs   = dev[SW-1] ? -dev : dev;
    var_abs   = var_q[SW-1] ? -var_q : var_q;
    d1        = cent_q - held_q;
    d2        = cent_q - var_q;
    pdiff     = var_q - held_q;
    pdiff_abs = pdiff[SW-1] ? -pdiff : pdiff;
    ed        = (d2 > d1) ? d2 : d1;
    ep_neg    = (d2 > d1) ? -d1 : -d2;
    ued       = ed[SW-1] ? '0 : ed;
    uep       = ep_neg[SW-1] ? '0 : ep_neg;
    prod64    = AccW'(prod);
    addend    = sel_q.quarter ? (prod64 >> 2) : prod64;
    msum_add  = {1'b0, msum_q} + {1'b0, addend};
    psum_add  = {1'b0, psum_q} + {1'b0, addend};
    vsum_abs  = AccW'(vsum_q[SumW-1] ? -vsum_q : vsum_q);
  end

  // start requests to the shared divide/root unit
  always_comb begin
    iter_ctrl.start = 1'b0;
    iter_ctrl.op    = OP_SQRT;
    iter_opnd       = msum_q;
    case (state_q)
      S_CHK: begin
        if (last_q) begin
          if (mode_q == MODE_REPLICA && cnt_q != '0) begin
            iter_ctrl.start = 1'b1;
            iter_ctrl.op    = OP_DIV;
            iter_opnd       = vsum_abs;
          end else if (mode_q inside {MODE_PAIRED, MODE_DEVIATION}) begin
            iter_ctrl.start = 1'b1;
          end
        end
      end
      S_MSQ: begin
        iter_ctrl.start = 1'b1;
        iter_ctrl.op    = OP_DIV;
      end
      S_DIV2: begin
        iter_opnd = iter_res - prod64;
        if (iter_done && iter_res > prod64) begin
          iter_ctrl.start = 1'b1;
        end
      end
      S_SQ1: begin
        iter_opnd = psum_q;
        if (iter_done && mode_q != MODE_REPLICA) begin
          iter_ctrl.start = 1'b1;
        end
      end
      default: ;
    endcase
  end

  vseb_mul #(
    .OpW (MagW)
  ) u_mul (
    .clk_i  (clk_i),
    .en_i   (state_q == S_MUL || state_q == S_MSQ),
    .a_i    (mul_a_q),
    .prod_o (prod)
  );

  vseb_iter #(
    .DivisorW (CntW)
  ) u_iter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (iter_ctrl),
    .opnd_i    (iter_opnd),
    .divisor_i (cnt_q),
    .busy_o    (iter_busy),
    .done_o    (iter_done),
    .result_o  (iter_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      mode_q    <= MODE_PAIRED;
      sym_q     <= 1'b0;
      cent_q    <= '0;
      var_q     <= '0;
      held_q    <= '0;
      last_q    <= 1'b0;
      phase_q   <= 1'b0;
      second_q  <= 1'b0;
      acc_sat_q <= 1'b0;
      vsum_q    <= '0;
      msum_q    <= '0;
      psum_q    <= '0;
      cnt_q     <= '0;
      max_up_q  <= '0;
      max_dn_q  <= '0;
      mul_a_q   <= '0;
      pend_q    <= '0;
      sel_q     <= '0;
      em_q      <= '0;
      ep_q      <= '0;
      m_valid_q <= 1'b0;
      out_sat_q <= 1'b0;
      out_em_q  <= '0;
      out_ep_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_ERROR_MODE) begin
          mode_q <= mode_e'(cfg_data_i[1:0]);
        end else begin
          sym_q <= cfg_data_i[0];
        end
      end
      // the result load in S_OUT sets valid itself
      if (m_axis_tready && state_q != S_OUT) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            cent_q  <= SW'(cent_raw);
            var_q   <= SW'(var_raw);
            last_q  <= s_axis_tlast;
            state_q <= S_ITEM;
          end
        end
        S_ITEM: begin
          if (cnt_q < CntW'(MAX_SETS)) begin
            cnt_q <= cnt_q + 1'b1;
            case (mode_q)
              MODE_REPLICA: begin
                vsum_q   <= vsum_q + SumW'(var_q);
                mul_a_q  <= var_abs[MagW-1:0];
                sel_q    <= '{to_minus: 1'b1, to_plus: 1'b0, quarter: 1'b0};
                second_q <= 1'b1;
                state_q  <= S_MUL;
              end
              MODE_PAIRED: begin
                if (!phase_q) begin
                  held_q  <= var_q;
                  phase_q <= 1'b1;
                  state_q <= S_CHK;
                end else begin
                  phase_q  <= 1'b0;
                  second_q <= sym_q;
                  state_q  <= S_MUL;
                  if (sym_q) begin
                    mul_a_q <= pdiff_abs[MagW-1:0];
                    sel_q   <= '{to_minus: 1'b1, to_plus: 1'b1, quarter: 1'b1};
                  end else begin
                    mul_a_q <= ued[MagW-1:0];
                    pend_q  <= uep[MagW-1:0];
                    sel_q   <= '{to_minus: 1'b1, to_plus: 1'b0, quarter: 1'b0};
                  end
                end
              end
              MODE_DEVIATION: begin
                mul_a_q  <= dev_abs[MagW-1:0];
                sel_q    <= '{to_minus: 1'b1, to_plus: 1'b1, quarter: 1'b0};
                second_q <= 1'b1;
                state_q  <= S_MUL;
              end
              default: begin
                state_q <= S_CHK;
                if (sym_q) begin
                  if (dev_abs[MagW-1:0] > max_up_q) begin
                    max_up_q <= dev_abs[MagW-1:0];
                    max_dn_q <= dev_abs[MagW-1:0];
                  end
                end else if (!dev[SW-1] && dev != '0) begin
                  if (dev_abs[MagW-1:0] > max_up_q) max_up_q <= dev_abs[MagW-1:0];
                end else begin
                  if (dev_abs[MagW-1:0] > max_dn_q) max_dn_q <= dev_abs[MagW-1:0];
                end
              end
            endcase
          end else begin
            state_q <= S_CHK;
          end
        end
        S_MUL: begin
          state_q <= S_ADD;
        end
        S_ADD: begin
          if (sel_q.to_minus) begin
            msum_q <= msum_add[AccW] ? {AccW{1'b1}} : msum_add[AccW-1:0];
          end
          if (sel_q.to_plus) begin
            psum_q <= psum_add[AccW] ? {AccW{1'b1}} : psum_add[AccW-1:0];
          end
          if ((sel_q.to_minus && msum_add[AccW]) ||
              (sel_q.to_plus && psum_add[AccW])) begin
            acc_sat_q <= 1'b1;
          end
          if (!second_q) begin
            // asymmetric pair: upward square goes to the plus sum
            mul_a_q  <= pend_q;
            sel_q    <= '{to_minus: 1'b0, to_plus: 1'b1, quarter: 1'b0};
            second_q <= 1'b1;
            state_q  <= S_MUL;
          end else begin
            state_q <= S_CHK;
          end
        end
        S_CHK: begin
          if (!last_q) begin
            state_q <= S_IDLE;
          end else begin
            case (mode_q)
              MODE_REPLICA: begin
                if (cnt_q == '0) begin
                  em_q    <= '0;
                  ep_q    <= '0;
                  state_q <= S_OUT;
                end else begin
                  state_q <= S_DIV1;
                end
              end
              MODE_PAIRED, MODE_DEVIATION: state_q <= S_SQ1;
              default: begin
                em_q    <= ErrRawW'(max_dn_q);
                ep_q    <= ErrRawW'(max_up_q);
                state_q <= S_OUT;
              end
            endcase
          end
        end
        S_DIV1: begin
          if (iter_done) begin
            mul_a_q <= iter_res[MagW-1:0];  // |mean|
            state_q <= S_MSQ;
          end
        end
        S_MSQ: begin
          state_q <= S_DIV2;
        end
        S_DIV2: begin
          if (iter_done) begin
            if (iter_res > prod64) begin
              state_q <= S_SQ1;
            end else begin
              em_q    <= '0;
              ep_q    <= '0;
              state_q <= S_OUT;
            end
          end
        end
        S_SQ1: begin
          if (iter_done) begin
            em_q <= iter_res[ErrRawW-1:0];
            if (mode_q == MODE_REPLICA) begin
              ep_q    <= iter_res[ErrRawW-1:0];
              state_q <= S_OUT;
            end else begin
              state_q <= S_SQ2;
            end
          end
        end
        S_SQ2: begin
          if (iter_done) begin
            ep_q    <= iter_res[ErrRawW-1:0];
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            out_em_q  <= clip_err(em_q);
            out_ep_q  <= clip_err(ep_q);
            out_sat_q <= acc_sat_q | em_q[ErrRawW-1] | ep_q[ErrRawW-1];
            vsum_q    <= '0;
            msum_q    <= '0;
            psum_q    <= '0;
            cnt_q     <= '0;
            held_q    <= '0;
            phase_q   <= 1'b0;
            max_up_q  <= '0;
            max_dn_q  <= '0;
            acc_sat_q <= 1'b0;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(2*FieldW-2*ErrW){1'b0}}, out_ep_q, out_em_q};
  assign m_axis_tuser  = out_sat_q;

  // point state is cleared when its result is loaded
  a_clear_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_free) |=> (cnt_q == '0 && m_axis_tvalid))
    else $error("point state not cleared with result");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_SETS))
    else $error("item count past limit");

  a_iter_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iter_ctrl.start |-> !iter_busy)
    else $error("shared unit started while busy");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second request taken during item");

endmodule

FILE: verif/variation_set_error_band_tb.sv
// Testbench for variation_set_error_band: drives points of variation values in
// every error mode and checks each error band against a predictor held in a
// scoreboard class. Depends on vseb_pkg and the block itself.
module variation_set_error_band_tb;
  import vseb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SetLimit   = 1024;
  localparam int StallLimit = 20000;
  localparam int DrainWait  = 300;

  typedef struct {
    logic [ErrW-1:0] err_minus;
    logic [ErrW-1:0] err_plus;
    logic            sat;
  } band_t;

  class band_scoreboard;
    mode_e              mode;
    bit                 sym;
    longint             value_sum;
    bit [63:0]          minus_sq, plus_sq;
    int unsigned        count;
    longint             held_minus;
    bit                 pair_phase;
    bit [31:0]          max_up, max_down;
    bit                 acc_sat;
    band_t              pending[$];
    int                 errors;
    int                 points[4];

    function new();
      mode = MODE_PAIRED;
      sym  = 0;
      errors = 0;
      clear_point();
    endfunction

    function void clear_point();
      value_sum = 0; minus_sq = 0; plus_sq = 0; count = 0;
      held_minus = 0; pair_phase = 0; max_up = 0; max_down = 0; acc_sat = 0;
    endfunction

    function void report(string what);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, what);
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == CFG_ERROR_MODE) mode = mode_e'(data);
      else sym = data[0];
    endfunction

    function bit [63:0] magnitude(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function void add_sat(ref bit [63:0] acc, input bit [63:0] v);
      if (acc > ~v) begin
        acc = '1;
        acc_sat = 1;
      end else begin
        acc += v;
      end
    endfunction

    function bit [63:0] int_root(bit [63:0] v);
      bit [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function logic [ErrW-1:0] clip(bit [63:0] v, ref bit flag);
      if (v > 64'h7FFF_FFFF) begin
        flag = 1;
        return '1;
      end
      return v[ErrW-1:0];
    endfunction

    function void pair_in(longint cent, longint vm, longint vp);
      bit [63:0] a, e2, ued, uep;
      longint d1, d2, ed, ep;
      if (sym) begin
        a  = magnitude(vp - vm);
        e2 = (a * a) >> 2;
        add_sat(minus_sq, e2);
        add_sat(plus_sq, e2);
      end else begin
        d1 = cent - vm;
        d2 = cent - vp;
        ed = d2 > d1 ? d2 : d1;
        ep = -d2 > -d1 ? -d2 : -d1;
        ued = ed < 0 ? 0 : 64'(ed);
        uep = ep < 0 ? 0 : 64'(ep);
        add_sat(minus_sq, ued * ued);
        add_sat(plus_sq, uep * uep);
      end
    endfunction

    // one accepted request; queues a band when it closes the point
    function void note_input(logic [2*FieldW-1:0] tdata, logic is_last);
      longint    cent, v, d, mean;
      bit [63:0] ad, em, ep, msq, sqm;
      bit        flag;
      band_t     b;
      cent = longint'($signed(tdata[FieldW-1:0]));
      v    = longint'($signed(tdata[2*FieldW-1:FieldW]));
      d    = v - cent;
      ad   = magnitude(d);
      if (count < SetLimit) begin
        case (mode)
          MODE_REPLICA: begin
            value_sum += v;
            add_sat(minus_sq, magnitude(v) * magnitude(v));
          end
          MODE_PAIRED: begin
            if (!pair_phase) begin
              held_minus = v;
              pair_phase = 1;
            end else begin
              pair_in(cent, held_minus, v);
              pair_phase = 0;
            end
          end
          MODE_DEVIATION: begin
            add_sat(minus_sq, ad * ad);
            add_sat(plus_sq, ad * ad);
          end
          default: begin
            if (sym) begin
              if (ad > max_up) begin
                max_up = ad[31:0];
                max_down = ad[31:0];
              end
            end else if (d > 0) begin
              if (ad > max_up) max_up = ad[31:0];
            end else if (ad > max_down) begin
              max_down = ad[31:0];
            end
          end
        endcase
        count++;
      end
      if (!is_last) return;
      flag = acc_sat;
      case (mode)
        MODE_REPLICA: begin
          em = 0;
          if (count > 0) begin
            mean = value_sum / longint'(count);
            msq  = minus_sq / count;
            sqm  = magnitude(mean) * magnitude(mean);
            em   = msq > sqm ? int_root(msq - sqm) : 0;
          end
          ep = em;
        end
        MODE_PAIRED, MODE_DEVIATION: begin
          em = int_root(minus_sq);
          ep = int_root(plus_sq);
        end
        default: begin
          em = max_down;
          ep = max_up;
        end
      endcase
      b.err_minus = clip(em, flag);
      b.err_plus  = clip(ep, flag);
      b.sat       = flag;
      pending.insert(pending.size(), b);
      points[mode]++;
      clear_point();
    endfunction

    function void check_result(logic [2*FieldW-1:0] tdata, logic tuser);
      band_t b;
      if (pending.size() == 0) begin
        report($sformatf("unexpected band %h", tdata));
        return;
      end
      b = pending.pop_front();
      if (tdata[ErrW-1:0] !== b.err_minus)
        report($sformatf("error_minus %h, want %h", tdata[ErrW-1:0], b.err_minus));
      if (tdata[2*ErrW-1:ErrW] !== b.err_plus)
        report($sformatf("error_plus %h, want %h", tdata[2*ErrW-1:ErrW], b.err_plus));
      if (tuser !== b.sat)
        report($sformatf("saturated %b, want %b", tuser, b.sat));
    endfunction
  endclass

  logic                  clk_i = 0;
  logic                  rst_ni = 0;
  logic                  cfg_valid_i = 0;
  logic                  cfg_ready_o;
  logic [CfgIdxW-1:0]    cfg_index_i = '0;
  logic [CfgDataW-1:0]   cfg_data_i = '0;
  logic                  s_axis_tvalid = 0;
  logic                  s_axis_tready;
  logic [2*FieldW-1:0]   s_axis_tdata = '0;  // central_value, variation_value
  logic                  s_axis_tlast = 0;   // last
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 0;
  logic [2*FieldW-1:0]   m_axis_tdata;       // error_minus, error_plus, zero pad
  logic                  m_axis_tuser;       // saturated

  band_scoreboard sb = new();
  bit  quiet = 0;      // no idling in the closing stretch
  bit  hold_req = 0;   // asks the receiver for one long hold-off
  int  idle_cnt = 0;
  int  items_sent = 0;

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  variation_set_error_band dut (.*);

  // accepted requests, results and register writes
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata, s_axis_tlast);
    if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
  end

  always @(posedge clk_i) begin
    if (idle_cnt >= StallLimit) begin
      $display("watchdog: no progress for %0d cycles", StallLimit);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        m_axis_tready = 0;
        for (n = 0; n < 400; n++) @(negedge clk_i);
      end
      if (!quiet && $urandom_range(0, 7) == 0) begin
        m_axis_tready = 0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
      m_axis_tready = 1;
    end
  end

  task automatic send_item(logic [31:0] cent, logic [31:0] var_v, logic is_last);
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid = 0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_axis_tvalid = 1;
    s_axis_tdata  = {var_v, cent};
    s_axis_tlast  = is_last;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid = 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 0;
  endtask

  task automatic set_mode(mode_e m, logic s);
    settle();
    write_cfg(CFG_ERROR_MODE, m);
    write_cfg(CFG_SYMMETRIC, {1'b0, s});
  endtask

  function automatic logic [31:0] near(logic [31:0] c);
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return c ^ (32'd1 << $urandom_range(0, 31));
      default: return c + $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
    endcase
  endfunction

  task automatic random_point(int len);
    logic [31:0] c;
    c = ($urandom_range(0, 9) == 0) ? $urandom() : ($urandom() >>> 4);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) c = $urandom();  // central drifts
      send_item(c, near(c), i == len - 1);
    end
  endtask

  initial begin
    int       len;
    mode_e    m;
    repeat (5) @(negedge clk_i);
    rst_ni = 1;

    // reset settings: paired asymmetric, with an unpaired trailing minus
    send_item(32'h0100_0000, 32'h0080_0000, 1'b0);
    send_item(32'h0100_0000, 32'h0180_0000, 1'b0);
    send_item(32'h0100_0000, 32'h7FFF_FFFF, 1'b1);
    set_mode(MODE_PAIRED, 1'b1);
    send_item(32'h8000_0000, 32'h8000_0000, 1'b0);
    send_item(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    // square sums overflow
    set_mode(MODE_DEVIATION, 1'b0);
    for (int i = 0; i < 4; i++) send_item(32'h7FFF_FFFF, 32'h8000_0000, i == 3);
    // envelope, one-sided then symmetric, with a clipped magnitude
    set_mode(MODE_ENVELOPE, 1'b0);
    send_item(32'h0000_0000, 32'h0100_0000, 1'b0);
    send_item(32'h0000_0000, 32'hFF00_0000, 1'b0);
    send_item(32'h0000_0000, 32'h0000_0000, 1'b1);
    set_mode(MODE_ENVELOPE, 1'b1);
    send_item(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    // replica std dev: single value, spread values
    set_mode(MODE_REPLICA, 1'b0);
    send_item(32'h0, 32'h0123_4567, 1'b1);
    send_item(32'h0, 32'h8000_0000, 1'b0);
    send_item(32'h0, 32'h7FFF_FFFF, 1'b0);
    send_item(32'h0, 32'hFFFF_FFFF, 1'b1);
    // mode change in the middle of a point
    send_item(32'h0100_0000, 32'h0300_0000, 1'b0);
    settle();
    write_cfg(CFG_ERROR_MODE, MODE_DEVIATION);
    send_item(32'h0100_0000, 32'hFF00_0000, 1'b1);

    // random phases, every mode and symmetry
    while (items_sent < 650) begin
      m = mode_e'($urandom_range(0, 3));
      set_mode(m, 1'($urandom_range(0, 1)));
      for (int p = 0; p < 25; p++) begin
        len = $urandom_range(0, 4) == 0 ? $urandom_range(9, 24) : $urandom_range(1, 8);
        if (p == 10 && !quiet && (items_sent < 400 || $urandom_range(0, 3) == 0))
          hold_req = 1;
        if (items_sent > 600) quiet = 1;
        random_point(len);
      end
    end
    // one point running past the set limit, no idling
    quiet = 1;
    set_mode(MODE_DEVIATION, 1'b0);
    random_point(SetLimit + 6);

    settle();
    repeat (DrainWait) @(posedge clk_i);
    while (sb.pending.size() != 0) begin
      sb.report("band never delivered");
      void'(sb.pending.pop_front());
    end
    $display("%0d requests; bands per mode replica/paired/deviation/envelope: %0d/%0d/%0d/%0d",
             items_sent, sb.points[0], sb.points[1], sb.points[2], sb.points[3]);
    $display("%0d mismatches", sb.errors);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
